// File: rtl/pcxrld_pkg.sv
// ----------------------------------------------------------------------------
// pcxrld_pkg
// Shared types and constants for the PCX run-length line decoder.
// ----------------------------------------------------------------------------
package pcxrld_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned RunW     = 6;
  localparam int unsigned ColW     = 17;
  localparam int unsigned LineW    = 16;

  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LINE_PITCH   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT = 2'd2;

  localparam logic [CfgDataW-1:0] RST_IMAGE_WIDTH  = 16'd320;
  localparam logic [CfgDataW-1:0] RST_LINE_PITCH   = 16'd320;
  localparam logic [CfgDataW-1:0] RST_IMAGE_HEIGHT = 16'd200;

  // top two bits of a run prefix byte
  localparam logic [1:0] RUN_MARK = 2'b11;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic accept;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic is_prefix;
    logic reps_zero;
    logic cnt_last;
    logic slot_free;
  } status_t;

endpackage

// File: rtl/pcxrld_ctrl.sv
// ----------------------------------------------------------------------------
// pcxrld_ctrl
// Controller: takes an item and, for a literal or run value, steps its pixel loop.
// ----------------------------------------------------------------------------
module pcxrld_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  pcxrld_pkg::status_t status,
  output pcxrld_pkg::cmd_t    cmd
);

  pcxrld_pkg::state_t state;
  pcxrld_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcxrld_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pcxrld_pkg::ST_IDLE: begin
        if (in_valid && !status.skip && !status.is_prefix && !status.reps_zero) begin
          state_next = pcxrld_pkg::ST_EMIT;
        end
      end
      pcxrld_pkg::ST_EMIT: begin
        if (status.slot_free && status.cnt_last) begin
          state_next = pcxrld_pkg::ST_IDLE;
        end
      end
      default: state_next = pcxrld_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      pcxrld_pkg::ST_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.accept   = in_valid;
      end
      pcxrld_pkg::ST_EMIT: begin
        cmd.step = status.slot_free;
      end
      default: cmd = '0;
    endcase
  end

  a_no_take_while_emit: assert property (@(posedge clk) disable iff (rst)
    (state == pcxrld_pkg::ST_EMIT) |-> (!cmd.in_ready && !cmd.accept))
    else $error("item taken during pixel loop");

  a_loop_ends: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && status.cnt_last) |=> (state == pcxrld_pkg::ST_IDLE))
    else $error("pixel loop ran past its count");

  a_loop_starts: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && !status.skip && !status.is_prefix && !status.reps_zero)
      |=> (state == pcxrld_pkg::ST_EMIT))
    else $error("data byte did not start pixel loop");

endmodule

// File: rtl/pcxrld_dp.sv
// ----------------------------------------------------------------------------
// pcxrld_dp
// Datapath: config registers, decode state, pixel loop counters, output reg.
// ----------------------------------------------------------------------------
module pcxrld_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  pcxrld_pkg::cmd_t                  cmd,
  output pcxrld_pkg::status_t               status,
  input  logic                              cfg_valid,
  input  logic [pcxrld_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [pcxrld_pkg::CfgDataW-1:0]   cfg_data,
  input  logic [pcxrld_pkg::ByteW-1:0]      code_byte,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [pcxrld_pkg::ByteW-1:0]      pixel,
  output logic                              last_of_byte,
  output logic                              image_done
);

  logic [pcxrld_pkg::CfgDataW-1:0] image_width;
  logic [pcxrld_pkg::CfgDataW-1:0] line_pitch;
  logic [pcxrld_pkg::CfgDataW-1:0] image_height;

  logic                          run_pending;
  logic [pcxrld_pkg::RunW-1:0]   run_length;
  logic [pcxrld_pkg::ColW-1:0]   column;
  logic [pcxrld_pkg::LineW-1:0]  line_index;
  logic                          finished;

  logic [pcxrld_pkg::ByteW-1:0]  value;
  logic [pcxrld_pkg::RunW-1:0]   count;
  logic [pcxrld_pkg::ColW-1:0]   emit_col;
  logic                          done_flag;

  logic [pcxrld_pkg::RunW-1:0]   reps;
  logic [pcxrld_pkg::ColW-1:0]   col_sum;
  logic [pcxrld_pkg::LineW-1:0]  line_inc;
  logic                          line_end;
  logic                          done_now;
  logic                          hit;
  logic                          last_hit;
  logic                          take_data;

  always_comb begin
    reps      = run_pending ? run_length : pcxrld_pkg::RunW'(1);
    col_sum   = column + pcxrld_pkg::ColW'(reps);
    line_end  = col_sum >= pcxrld_pkg::ColW'(line_pitch);
    line_inc  = line_index + pcxrld_pkg::LineW'(1);
    done_now  = line_end && (line_inc >= image_height);
    hit       = emit_col < pcxrld_pkg::ColW'(image_width);
    last_hit  = (count == pcxrld_pkg::RunW'(1)) ||
                ((emit_col + pcxrld_pkg::ColW'(1)) == pcxrld_pkg::ColW'(image_width));

    status.skip      = finished || (line_index >= image_height);
    status.is_prefix = !run_pending && (code_byte[7:6] == pcxrld_pkg::RUN_MARK);
    status.reps_zero = (reps == '0);
    status.cnt_last  = (count == pcxrld_pkg::RunW'(1));
    status.slot_free = !out_valid || out_ready;
  end

  assign take_data = cmd.accept && !status.skip && !status.is_prefix;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= pcxrld_pkg::RST_IMAGE_WIDTH;
      line_pitch   <= pcxrld_pkg::RST_LINE_PITCH;
      image_height <= pcxrld_pkg::RST_IMAGE_HEIGHT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pcxrld_pkg::CFG_IMAGE_WIDTH:  image_width  <= cfg_data;
        pcxrld_pkg::CFG_LINE_PITCH:   line_pitch   <= cfg_data;
        pcxrld_pkg::CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // decode state, updated once per accepted item that is not skipped
  always_ff @(posedge clk) begin
    if (rst) begin
      run_pending <= 1'b0;
      run_length  <= '0;
      column      <= '0;
      line_index  <= '0;
      finished    <= 1'b0;
    end else if (cmd.accept && !status.skip) begin
      if (status.is_prefix) begin
        run_pending <= 1'b1;
        run_length  <= code_byte[pcxrld_pkg::RunW-1:0];
      end else begin
        run_pending <= 1'b0;
        run_length  <= '0;
        if (line_end) begin
          column     <= '0;
          line_index <= line_inc;
          finished   <= done_now;
        end else begin
          column <= col_sum;
        end
      end
    end
  end

  // pixel loop registers
  always_ff @(posedge clk) begin
    if (take_data) begin
      value     <= code_byte;
      count     <= reps;
      emit_col  <= column;
      done_flag <= done_now;
    end else if (cmd.step) begin
      count    <= count - pcxrld_pkg::RunW'(1);
      emit_col <= emit_col + pcxrld_pkg::ColW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step && hit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && hit) begin
      pixel        <= value;
      last_of_byte <= last_hit;
      image_done   <= last_hit && done_flag;
    end
  end

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && image_done) |-> last_of_byte)
    else $error("image_done without last_of_byte");

  a_finish_from_item: assert property (@(posedge clk) disable iff (rst)
    $rose(finished) |-> $past(cmd.accept))
    else $error("finished set without an item");

  a_finished_skips: assert property (@(posedge clk) disable iff (rst)
    finished |-> status.skip)
    else $error("finished block not skipping items");

endmodule

// File: rtl/pcx_rle_line_decoder_unit.sv
// ----------------------------------------------------------------------------
// pcx_rle_line_decoder_unit
// PCX 8-bit single-plane run-length decoder, one code byte per item.
//
//   channel  dir  handshake            payload
//   in       in   in_valid/in_ready    code_byte[7:0]
//   out      out  out_valid/out_ready  pixel[7:0], last_of_byte, image_done
//   cfg      in   cfg_valid/cfg_ready  cfg_index[1:0], cfg_data[15:0]
//
// A run prefix, a zero-length run or an ignored byte is taken without a pixel loop.
// A literal steps one pixel and a run value of count N steps N pixels, one pixel
// per cycle from the shared emit column counter; those past the width are dropped.
// Output stalls hold the pixel loop; the output register lets a new item be
// taken while the last pixel waits. Reset sets width/pitch 320, height 200.
// ----------------------------------------------------------------------------
module pcx_rle_line_decoder_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [pcxrld_pkg::ByteW-1:0]    code_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pcxrld_pkg::ByteW-1:0]    pixel,
  output logic                            last_of_byte,
  output logic                            image_done,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pcxrld_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [pcxrld_pkg::CfgDataW-1:0] cfg_data
);

  pcxrld_pkg::cmd_t    cmd;
  pcxrld_pkg::status_t status;

  assign in_ready  = cmd.in_ready;
  assign cfg_ready = 1'b1;

  pcxrld_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .cmd      (cmd)
  );

  pcxrld_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .code_byte    (code_byte),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .pixel        (pixel),
    .last_of_byte (last_of_byte),
    .image_done   (image_done)
  );

endmodule

// File: tb/pcx_rle_line_decoder_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pcx_rle_line_decoder_unit_tb
// Self-checking bench for the PCX run-length line decoder. Code bytes are
// fed in bursts with random gaps while the pixel side stalls on changing
// patterns. Each accepted byte runs through a local decoder model, and every
// pixel leaving the block is checked in order against it. Register settings
// move through zero, small and full-scale values, and the run ends on the
// last line of a small image.
// ----------------------------------------------------------------------------
module pcx_rle_line_decoder_unit_tb;

  localparam logic [pcxrld_pkg::CfgIdxW-1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned SettleCycles = 100;

  typedef struct packed {
    logic [pcxrld_pkg::ByteW-1:0] value;
    logic                         last;
    logic                         done;
  } pixel_exp_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [pcxrld_pkg::ByteW-1:0]    code_byte = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [pcxrld_pkg::ByteW-1:0]    pixel;
  logic                            last_of_byte;
  logic                            image_done;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [pcxrld_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [pcxrld_pkg::CfgDataW-1:0] cfg_data = '0;

  pcx_rle_line_decoder_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .code_byte    (code_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel        (pixel),
    .last_of_byte (last_of_byte),
    .image_done   (image_done),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #1 clk = ~clk;

  // decoder model state and register copies
  logic [pcxrld_pkg::CfgDataW-1:0] width_reg  = pcxrld_pkg::RST_IMAGE_WIDTH;
  logic [pcxrld_pkg::CfgDataW-1:0] pitch_reg  = pcxrld_pkg::RST_LINE_PITCH;
  logic [pcxrld_pkg::CfgDataW-1:0] height_reg = pcxrld_pkg::RST_IMAGE_HEIGHT;
  logic                            run_armed = 1'b0;
  logic [pcxrld_pkg::RunW-1:0]     run_count = '0;
  logic [pcxrld_pkg::ColW-1:0]     col = '0;
  logic [pcxrld_pkg::LineW-1:0]    line_count = '0;
  logic                            img_finished = 1'b0;

  pixel_exp_t                   expected_pixels[$];
  logic [pcxrld_pkg::ByteW-1:0] pending_bytes[$];
  int                           bytes_outstanding = 0;
  int                           mismatch_count = 0;
  logic                         byte_accepted = 1'b0;
  logic                         cfg_accepted = 1'b0;
  pixel_exp_t                   want;

  int               gap_left = 0;
  int               burst_left = 8;
  int               pat_left = 0;
  int unsigned      pat_pos = 0;
  logic [7:0]       ready_pat = 8'hFF;

  task automatic report_mismatch(input string what);
    $display("ERROR %0t: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic decode_code_byte(input logic [pcxrld_pkg::ByteW-1:0] b);
    int unsigned reps;
    int          produced;
    int          tail;
    produced = 0;
    if (img_finished || line_count >= height_reg) return;
    if (!run_armed && b[7:6] == pcxrld_pkg::RUN_MARK) begin
      run_armed = 1'b1;
      run_count = b[pcxrld_pkg::RunW-1:0];
      return;
    end
    reps = run_armed ? run_count : 1;
    run_armed = 1'b0;
    run_count = '0;
    for (int unsigned k = 0; k < reps; k++) begin
      if (col < {1'b0, width_reg}) begin
        expected_pixels.push_back('{value: b, last: 1'b0, done: 1'b0});
        produced++;
      end
      col = col + 1'b1;
    end
    if (col >= {1'b0, pitch_reg}) begin
      col = '0;
      line_count = line_count + 1'b1;
      if (line_count >= height_reg) img_finished = 1'b1;
    end
    if (produced > 0) begin
      tail = expected_pixels.size() - 1;
      expected_pixels[tail].last = 1'b1;
      expected_pixels[tail].done = img_finished;
    end
  endtask

  // sample at the rising edge
  always @(posedge clk) begin
    byte_accepted <= in_valid && in_ready;
    cfg_accepted  <= cfg_valid && cfg_ready;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("pixel %02h with none expected", pixel));
        end else begin
          want = expected_pixels.pop_front();
          if (pixel !== want.value)
            report_mismatch($sformatf("pixel %02h, want %02h", pixel, want.value));
          if (last_of_byte !== want.last)
            report_mismatch($sformatf("last_of_byte %b, want %b", last_of_byte, want.last));
          if (image_done !== want.done)
            report_mismatch($sformatf("image_done %b, want %b", image_done, want.done));
        end
      end
      if (in_valid && in_ready) begin
        decode_code_byte(code_byte);
        bytes_outstanding--;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pcxrld_pkg::CFG_IMAGE_WIDTH:  width_reg  = cfg_data;
          pcxrld_pkg::CFG_LINE_PITCH:   pitch_reg  = cfg_data;
          pcxrld_pkg::CFG_IMAGE_HEIGHT: height_reg = cfg_data;
          default: ;
        endcase
      end
    end
  end

  // byte driver: bursts with random gaps
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || byte_accepted) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        code_byte <= pending_bytes.pop_front();
        in_valid  <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // pixel side stalls on a repeating 8-bit ready pattern, picked anew at random
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (pat_left == 0) begin
        case ($urandom_range(0, 3))
          0: ready_pat = 8'hFF;
          1: ready_pat = 8'($urandom);
          2: ready_pat = 8'h11;
          default: ready_pat = 8'($urandom | $urandom);
        endcase
        pat_left = 64;
      end
      out_ready <= ready_pat[pat_pos % 8];
      pat_pos++;
      pat_left--;
    end
  end

  task automatic push_byte(input logic [pcxrld_pkg::ByteW-1:0] b);
    pending_bytes.push_back(b);
    bytes_outstanding++;
  endtask

  task automatic write_reg(input logic [pcxrld_pkg::CfgIdxW-1:0]  idx,
                           input logic [pcxrld_pkg::CfgDataW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_accepted);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (bytes_outstanding != 0 || expected_pixels.size() != 0);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // mostly literals and run pairs, with some arbitrary bytes mixed in
  task automatic queue_random(input int n);
    int unsigned sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
        push_byte(8'($urandom_range(0, 191)));
      end else if (sel < 9) begin
        if ($urandom_range(0, 3) == 0)
          push_byte({pcxrld_pkg::RUN_MARK, 6'($urandom_range(0, 63))});
        else
          push_byte({pcxrld_pkg::RUN_MARK, 6'($urandom_range(0, 6))});
        push_byte(8'($urandom_range(0, 255)));
      end else begin
        push_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // reset settings: literal extremes, zero-length run, full run, marked values
    push_byte(8'h00); push_byte(8'h3F); push_byte(8'h40); push_byte(8'h80);
    push_byte(8'hBF);
    push_byte(8'hC0); push_byte(8'h5A);
    push_byte(8'hC1); push_byte(8'hFF);
    push_byte(8'hFF); push_byte(8'h00);
    push_byte(8'hC3); push_byte(8'hC0);
    push_byte(8'hC2); push_byte(8'hA5);
    push_byte(8'h7F); push_byte(8'h01);
    wait_idle();

    // zero width and pitch: every non-prefix byte ends a line, nothing comes out
    write_reg(pcxrld_pkg::CFG_IMAGE_WIDTH, 16'd0);
    write_reg(pcxrld_pkg::CFG_LINE_PITCH, 16'd0);
    push_byte(8'h12); push_byte(8'hC5); push_byte(8'h34); push_byte(8'h56);
    wait_idle();

    // zero height: bytes ignored
    write_reg(pcxrld_pkg::CFG_IMAGE_HEIGHT, 16'd0);
    write_reg(CFG_UNUSED, 16'hFFFF);
    push_byte(8'h21); push_byte(8'hC2); push_byte(8'h33);
    wait_idle();

    write_reg(pcxrld_pkg::CFG_IMAGE_WIDTH, 16'hFFFF);
    write_reg(pcxrld_pkg::CFG_LINE_PITCH, 16'hFFFF);
    write_reg(pcxrld_pkg::CFG_IMAGE_HEIGHT, 16'hFFFF);
    queue_random(15);
    wait_idle();

    repeat (3) begin
      write_reg(pcxrld_pkg::CFG_IMAGE_WIDTH, 16'($urandom_range(1, 40)));
      write_reg(pcxrld_pkg::CFG_LINE_PITCH, 16'($urandom_range(1, 48)));
      write_reg(pcxrld_pkg::CFG_IMAGE_HEIGHT, line_count + 16'd2000);
      queue_random(12);
      wait_idle();
    end

    // close the open line so the last image starts at column zero
    write_reg(pcxrld_pkg::CFG_IMAGE_WIDTH, 16'd5);
    write_reg(pcxrld_pkg::CFG_LINE_PITCH, 16'd0);
    if (run_armed) push_byte(8'h00);
    push_byte(8'h11);
    wait_idle();

    // two 8-column lines, 5 pixels kept
    write_reg(pcxrld_pkg::CFG_LINE_PITCH, 16'd8);
    write_reg(pcxrld_pkg::CFG_IMAGE_HEIGHT, line_count + 16'd2);
    repeat (8) push_byte(8'($urandom_range(0, 191)));
    repeat (4) push_byte(8'($urandom_range(0, 191)));
    if ($urandom_range(0, 1) == 0) begin
      push_byte(8'hC4);
      push_byte(8'($urandom_range(0, 255)));
    end else begin
      // final line ends on a run past the kept width
      push_byte(8'($urandom_range(0, 191)));
      push_byte(8'hC3);
      push_byte(8'($urandom_range(0, 255)));
    end
    push_byte(8'h00); push_byte(8'hC7); push_byte(8'hFF);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
